>>> design/spd_pkg.sv
// -----------------------------------------------------------------------------
// spd_pkg: shared types and constants for the signature packet deframer
// Field widths, stream packing, config register indexes and a byte selector.
// -----------------------------------------------------------------------------
package spd_pkg;

  // stream payload widths
  localparam int DataW     = 8;
  localparam int LenOutW   = 13;
  localparam int OutTdataW = 24;   // out_byte + packet_length, padded to bytes
  localparam int TuserW    = 2;    // packet_end, overflow

  // config port
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int SigLenW   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_LEN  = 3'd0,
    REG_START_SIG  = 3'd1,
    REG_END_LEN    = 3'd2,
    REG_END_SIG    = 3'd3,
    REG_MAX_LEN    = 3'd4
  } cfg_reg_e;

  // one result item
  typedef struct packed {
    logic [LenOutW-1:0] packet_length;
    logic               overflow;
    logic               packet_end;
    logic               run_last;
    logic [DataW-1:0]   out_byte;
  } res_t;

  // byte j of a signature word
  function automatic logic [DataW-1:0] sig_byte(logic [CfgDataW-1:0] sig,
                                                logic [2:0] j);
    sig_byte = sig[{j, 3'b000} +: DataW];
  endfunction

endpackage

>>> design/signature_packet_deframer.sv
// -----------------------------------------------------------------------------
// signature_packet_deframer: start/end signature packet delimiter
// Hunts for a start signature, passes the packet bytes on (start signature
// included) and closes the packet on the end signature or on overflow.
// -----------------------------------------------------------------------------
// Output: a packet byte is registered and shows on the master side in the cycle after its transfer.
// Throughput, when the master side does not stall: one byte per cycle inside a
//   packet and while hunting; a byte that completes the start signature holds the
//   slave side while the output register plays out the signature one byte a cycle.
// Reset: asynchronous, active low; clears hunt/packet state and loads the
//   register defaults (lengths 1, signatures 0, maximum length 4096).
module signature_packet_deframer #(
  parameter int MaxSigBytes = 8,
  parameter int MaxPacket   = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream; tdata: rx_byte[7:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [spd_pkg::DataW-1:0]     s_axis_tdata,
  // output stream; tdata: out_byte[7:0], packet_length[20:8], zero pad[23:21]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [spd_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,   // run_last
  // tuser: packet_end[0], overflow[1]
  output logic [spd_pkg::TuserW-1:0]    m_axis_tuser,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import spd_pkg::*;

  localparam int SigW = 8 * MaxSigBytes;
  localparam int CntW = $clog2(MaxPacket + 1);
  localparam int LenW = (CntW > LenOutW) ? CntW : LenOutW;

  // config registers
  logic [SigLenW-1:0]  start_len_q, end_len_q;
  logic [CfgDataW-1:0] start_sig_q, end_sig_q;
  logic [LenOutW-1:0]  max_len_q;

  // hunt / packet state
  logic [SigLenW-1:0]  match_cnt_q, match_cnt_d;
  logic                in_pkt_q, in_pkt_d;
  logic [CntW-1:0]     byte_cnt_q, byte_cnt_d;
  logic [SigW-1:0]     tail_q, tail_d;

  // start signature play-out
  logic                burst_q, burst_d;
  logic [SigLenW-1:0]  burst_idx_q, burst_idx_d;

  // output register
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  logic [SigLenW-1:0]  slen, elen;
  logic [LenW-1:0]     maxlen;
  logic                slot_free, accept, load;

  // register writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_len_q <= SigLenW'(1);
      start_sig_q <= '0;
      end_len_q   <= SigLenW'(1);
      end_sig_q   <= '0;
      max_len_q   <= LenOutW'(4096);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_LEN: start_len_q <= cfg_data_i[SigLenW-1:0];
        REG_START_SIG: start_sig_q <= cfg_data_i;
        REG_END_LEN:   end_len_q   <= cfg_data_i[SigLenW-1:0];
        REG_END_SIG:   end_sig_q   <= cfg_data_i;
        REG_MAX_LEN:   max_len_q   <= cfg_data_i[LenOutW-1:0];
        default: ;
      endcase
    end
  end

  // clamp lengths into their legal ranges
  always_comb begin
    if (start_len_q == '0)                          slen = SigLenW'(1);
    else if (start_len_q > SigLenW'(MaxSigBytes))   slen = SigLenW'(MaxSigBytes);
    else                                            slen = start_len_q;
    if (end_len_q == '0)                            elen = SigLenW'(1);
    else if (end_len_q > SigLenW'(MaxSigBytes))     elen = SigLenW'(MaxSigBytes);
    else                                            elen = end_len_q;
    if (max_len_q == '0)                            maxlen = LenW'(1);
    else if (LenW'(max_len_q) > LenW'(MaxPacket))   maxlen = LenW'(MaxPacket);
    else                                            maxlen = LenW'(max_len_q);
  end

  // handshake
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !burst_q && slot_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // per-byte work
  always_comb begin
    logic [SigLenW-1:0] idx, idx_nx, bl_nx, epos, pi;
    logic               hit, full, end_hit, ovf_hit, b_last;
    logic [SigW-1:0]    tail_sh;
    logic [CntW-1:0]    cnt_nx;

    match_cnt_d = match_cnt_q;
    in_pkt_d    = in_pkt_q;
    byte_cnt_d  = byte_cnt_q;
    tail_d      = tail_q;
    burst_d     = burst_q;
    burst_idx_d = burst_idx_q;
    load        = 1'b0;
    out_d       = out_q;

    // hunt compare
    idx    = (match_cnt_q >= slen) ? '0 : match_cnt_q;
    hit    = (s_axis_tdata == sig_byte(start_sig_q, idx[2:0]));
    idx_nx = idx + SigLenW'(1);
    full   = hit && (idx_nx >= slen);

    // packet byte: shift into tail and check end signature
    tail_sh = SigW'({tail_q, s_axis_tdata});
    cnt_nx  = CntW'(byte_cnt_q + 1'b1);
    end_hit = (LenW'(cnt_nx) >= LenW'(elen));
    for (int p = 0; p < MaxSigBytes; p++) begin
      pi   = SigLenW'(p);
      epos = elen - pi - SigLenW'(1);
      if ((pi < elen) &&
          (tail_sh[8*p +: 8] != sig_byte(end_sig_q, epos[2:0]))) begin
        end_hit = 1'b0;
      end
    end
    ovf_hit = !end_hit && (LenW'(cnt_nx) >= maxlen);

    // start signature play-out step
    bl_nx  = burst_idx_q + SigLenW'(1);
    b_last = (bl_nx == slen);

    if (burst_q && slot_free) begin
      load                = 1'b1;
      out_d.out_byte      = sig_byte(start_sig_q, burst_idx_q[2:0]);
      out_d.run_last      = b_last;
      out_d.packet_end    = 1'b0;
      out_d.overflow      = b_last && (LenW'(slen) >= maxlen);
      out_d.packet_length = LenOutW'(bl_nx);
      burst_idx_d         = bl_nx;
      if (b_last) burst_d = 1'b0;
    end else if (accept && in_pkt_q) begin
      load                = 1'b1;
      out_d.out_byte      = s_axis_tdata;
      out_d.run_last      = 1'b1;
      out_d.packet_end    = end_hit;
      out_d.overflow      = ovf_hit;
      out_d.packet_length = LenOutW'(cnt_nx);
      if (end_hit || ovf_hit) begin
        in_pkt_d   = 1'b0;
        byte_cnt_d = '0;
        tail_d     = '0;
      end else begin
        byte_cnt_d = cnt_nx;
        tail_d     = tail_sh;
      end
    end else if (accept) begin
      if (!hit) begin
        match_cnt_d = '0;
      end else if (!full) begin
        match_cnt_d = idx_nx;
      end else begin
        match_cnt_d = '0;
        burst_d     = 1'b1;
        burst_idx_d = '0;
        if (LenW'(slen) >= maxlen) begin
          // start signature alone fills the packet: abandoned at once
          in_pkt_d   = 1'b0;
          byte_cnt_d = '0;
          tail_d     = '0;
        end else begin
          in_pkt_d   = 1'b1;
          byte_cnt_d = CntW'(slen);
          // newest start byte in the lowest lane
          for (int p = 0; p < MaxSigBytes; p++) begin
            pi   = SigLenW'(p);
            epos = slen - pi - SigLenW'(1);
            tail_d[8*p +: 8] = (pi < slen) ? sig_byte(start_sig_q, epos[2:0]) : 8'h00;
          end
        end
      end
    end

    // output register occupancy
    if (load)               out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
    else                    out_valid_d = out_valid_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_cnt_q <= '0;
      in_pkt_q    <= 1'b0;
      byte_cnt_q  <= '0;
      tail_q      <= '0;
      burst_q     <= 1'b0;
      burst_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      match_cnt_q <= match_cnt_d;
      in_pkt_q    <= in_pkt_d;
      byte_cnt_q  <= byte_cnt_d;
      tail_q      <= tail_d;
      burst_q     <= burst_d;
      burst_idx_q <= burst_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'({out_q.packet_length, out_q.out_byte});
  assign m_axis_tlast  = out_q.run_last;
  assign m_axis_tuser  = {out_q.overflow, out_q.packet_end};

endmodule

>>> design/spd_checker.sv
// -----------------------------------------------------------------------------
// spd_checker: port-level checks for the signature packet deframer
// Watches the stream ports and flags ordering or flag-coding slips.
// -----------------------------------------------------------------------------
module spd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [spd_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic [spd_pkg::TuserW-1:0]    m_axis_tuser
);
  import spd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // no new byte taken while a result is stuck
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready while output stalled");

  // end and overflow are exclusive
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("packet_end and overflow together");

  // flags only on the last result of a run, and length never zero
  a_flags_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != '0) |->
      m_axis_tlast && (m_axis_tdata[DataW +: LenOutW] != '0))
    else $error("flag off run end or zero length");

endmodule

bind signature_packet_deframer spd_checker u_spd_checker (.*);

>>> sim/tb_signature_packet_deframer.sv
// -----------------------------------------------------------------------------
// tb_signature_packet_deframer: self-checking testbench for the packet deframer
// Drives received bytes with bursty timing, stalls the output on shifting
// patterns, and checks every output transfer against an in-bench model of the
// start/end signature framing, across several register settings.
// -----------------------------------------------------------------------------

// Tracks hunt and packet state and holds the results each byte should produce.
class frame_tracker;
  localparam int unsigned MaxSig = 8;
  localparam int unsigned MaxPkt = 4096;
  localparam int unsigned ErrPrintMax = 30;

  // register copies
  logic [3:0]  start_len_q;
  logic [63:0] start_sig_q;
  logic [3:0]  end_len_q;
  logic [63:0] end_sig_q;
  logic [12:0] max_len_q;

  // framing state
  int unsigned match_idx;
  bit          in_pkt;
  int unsigned pkt_count;
  logic [63:0] tail;

  spd_pkg::res_t expected_q[$];

  int unsigned n_errors;
  int unsigned n_inputs;
  int unsigned n_checked;
  int unsigned n_ended;
  int unsigned n_overflows;

  function new();
    start_len_q = 4'd1;
    start_sig_q = '0;
    end_len_q   = 4'd1;
    end_sig_q   = '0;
    max_len_q   = 13'd4096;
    match_idx   = 0;
    in_pkt      = 1'b0;
    pkt_count   = 0;
    tail        = '0;
  endfunction

  // zero counts as one, anything above the ceiling counts as the ceiling
  function int unsigned clamp(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function int unsigned start_span();
    return clamp(start_len_q, MaxSig);
  endfunction

  function int unsigned end_span();
    return clamp(end_len_q, MaxSig);
  endfunction

  function logic [7:0] sig_at(logic [63:0] sig, int unsigned j);
    return sig[(j % 8) * 8 +: 8];
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void write_reg(spd_pkg::cfg_reg_e idx, logic [63:0] v);
    case (idx)
      spd_pkg::REG_START_LEN: start_len_q = v[3:0];
      spd_pkg::REG_START_SIG: start_sig_q = v;
      spd_pkg::REG_END_LEN:   end_len_q = v[3:0];
      spd_pkg::REG_END_SIG:   end_sig_q = v;
      spd_pkg::REG_MAX_LEN:   max_len_q = v[12:0];
      default: ;
    endcase
  endfunction

  // one accepted byte: advance the state, queue the results it causes
  function void note_input(logic [7:0] b);
    int unsigned slen;
    int unsigned elen;
    int unsigned maxlen;
    bit hit;
    spd_pkg::res_t r;
    slen   = start_span();
    elen   = end_span();
    maxlen = clamp(max_len_q, MaxPkt);
    n_inputs++;

    if (!in_pkt) begin
      // stale index after the start length was lowered mid-hunt
      if (match_idx >= slen) match_idx = 0;
      // mismatching byte is dropped, not compared against byte 0 again
      if (b != sig_at(start_sig_q, match_idx)) begin
        match_idx = 0;
        return;
      end
      match_idx++;
      if (match_idx < slen) return;
      match_idx = 0;
      in_pkt    = 1'b1;
      pkt_count = 0;
      tail      = '0;
      // replay the start signature; never checked against the end signature
      for (int unsigned j = 0; j < slen; j++) begin
        tail = {tail[55:0], sig_at(start_sig_q, j)};
        pkt_count++;
        r.out_byte      = sig_at(start_sig_q, j);
        r.run_last      = (j + 1 == slen);
        r.packet_end    = 1'b0;
        r.overflow      = (j + 1 == slen) && (pkt_count >= maxlen);
        r.packet_length = pkt_count[12:0];
        expected_q.push_back(r);
      end
      // start signature alone fills the maximum: abandon right away
      if (pkt_count >= maxlen) begin
        n_overflows++;
        in_pkt    = 1'b0;
        pkt_count = 0;
        tail      = '0;
      end
      return;
    end

    tail = {tail[55:0], b};
    pkt_count++;
    // end check over the newest elen bytes, oldest against signature byte 0
    hit = (pkt_count >= elen);
    for (int unsigned j = 0; j < elen; j++)
      if (tail[(elen - 1 - j) * 8 +: 8] != sig_at(end_sig_q, j)) hit = 1'b0;
    r.out_byte      = b;
    r.run_last      = 1'b1;
    r.packet_end    = hit;
    r.overflow      = !hit && (pkt_count >= maxlen);
    r.packet_length = pkt_count[12:0];
    expected_q.push_back(r);
    // end wins over overflow on the same byte
    if (r.packet_end || r.overflow) begin
      if (r.packet_end) n_ended++;
      else n_overflows++;
      in_pkt    = 1'b0;
      pkt_count = 0;
      tail      = '0;
    end
  endfunction

  function void report(string field, int unsigned exp_v, int unsigned got_v);
    n_errors++;
    if (n_errors <= ErrPrintMax)
      $error("%s: expected %0h, got %0h", field, exp_v, got_v);
  endfunction

  // one output transfer against the oldest expectation
  function void check_result(spd_pkg::res_t got);
    spd_pkg::res_t e;
    if (expected_q.size() == 0) begin
      n_errors++;
      if (n_errors <= ErrPrintMax)
        $error("unexpected output transfer: byte %0h len %0d",
               got.out_byte, got.packet_length);
      return;
    end
    e = expected_q.pop_front();
    n_checked++;
    if (got.out_byte !== e.out_byte) report("out_byte", e.out_byte, got.out_byte);
    if (got.run_last !== e.run_last) report("run_last", e.run_last, got.run_last);
    if (got.packet_end !== e.packet_end)
      report("packet_end", e.packet_end, got.packet_end);
    if (got.overflow !== e.overflow) report("overflow", e.overflow, got.overflow);
    if (got.packet_length !== e.packet_length)
      report("packet_length", e.packet_length, got.packet_length);
  endfunction
endclass

module tb_signature_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import spd_pkg::*;

  localparam int unsigned RstCycles = 11;
  localparam int unsigned DrainPad  = 20;
  localparam int unsigned IdleLimit = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DataW-1:0]     s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic [TuserW-1:0]    m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  frame_tracker tracker = new();

  int unsigned burst_left = 0;
  int unsigned n_sent = 0;
  int unsigned n_cfg = 0;
  int unsigned idle_cycles = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int unsigned pat_left = 0;

  always #2 clk_i = ~clk_i;

  signature_packet_deframer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // receiver: rotate a stall pattern, swap it for a new one now and then
  always @(posedge clk_i) begin
    m_axis_tready <= stall_pat[15];
    if (pat_left == 0) begin
      pat_left  <= $urandom_range(20, 200);
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    end else begin
      pat_left  <= pat_left - 1;
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
  end

  // transfer monitor: inputs are noted before outputs of the same edge
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) tracker.note_input(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready)
      tracker.check_result(res_t'{packet_length: m_axis_tdata[20:8],
                                  overflow:      m_axis_tuser[1],
                                  packet_end:    m_axis_tuser[0],
                                  run_last:      m_axis_tlast,
                                  out_byte:      m_axis_tdata[7:0]});
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one byte on the input stream, sent in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // stop sending and wait until every expected result has come out,
  // after first letting the monitor note the last transfer
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [63:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, v);
    n_cfg++;
  endtask

  task automatic set_framing(input logic [3:0] slen, input logic [63:0] ssig,
                             input logic [3:0] elen, input logic [63:0] esig,
                             input logic [12:0] maxlen);
    cfg_write(REG_START_LEN, 64'(slen));
    cfg_write(REG_START_SIG, ssig);
    cfg_write(REG_END_LEN, 64'(elen));
    cfg_write(REG_END_SIG, esig);
    cfg_write(REG_MAX_LEN, 64'(maxlen));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_start();
    for (int unsigned j = 0; j < tracker.start_span(); j++)
      send_byte(tracker.sig_at(tracker.start_sig_q, j));
  endtask

  function automatic logic [3:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      3: return 4'd1;
      default: return 4'($urandom_range(2, 4));
    endcase
  endfunction

  function automatic logic [12:0] pick_max();
    case ($urandom_range(0, 7))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd8191;
      default: return 13'($urandom_range(6, 40));
    endcase
  endfunction

  // random framing: mostly whole packets, some broken starts and noise
  task automatic random_phase(input int unsigned n_items, input logic [3:0] slen,
                              input logic [3:0] elen, input logic [12:0] maxlen);
    int unsigned target;
    int unsigned k;
    set_framing(slen, {$urandom(), $urandom()}, elen, {$urandom(), $urandom()}, maxlen);
    target = n_sent + n_items;
    while (n_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1: send_byte(8'($urandom()));
        2: begin
          // partial start signature, then a wrong byte
          k = $urandom_range(0, tracker.start_span() - 1);
          for (int unsigned j = 0; j < k; j++)
            send_byte(tracker.sig_at(tracker.start_sig_q, j));
          send_byte(tracker.sig_at(tracker.start_sig_q, k) ^ 8'($urandom_range(1, 255)));
        end
        default: begin
          send_start();
          repeat ($urandom_range(0, 8)) send_byte(8'($urandom()));
          for (int unsigned j = 0; j < tracker.end_span(); j++)
            send_byte(tracker.sig_at(tracker.end_sig_q, j));
        end
      endcase
    end
    drain();
  endtask

  initial begin
    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // start A5 5A FF, end 0D 0A, packets of up to 16 bytes
    set_framing(4'd3, 64'h00FF_5AA5, 4'd2, 64'h0A0D, 13'd16);
    // a repeated first byte breaks the match and is not retried
    send_seq('{8'hA5, 8'hA5, 8'h5A, 8'hFF});
    // full packet with extreme payload bytes, closed by the end signature
    send_seq('{8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h0D, 8'h0A});
    // leave the hunt two bytes deep, then shorten the start signature
    send_seq('{8'hA5, 8'h5A});
    drain();
    cfg_write(REG_START_LEN, 64'd2);
    cfg_valid_i <= 1'b0;
    send_seq('{8'hA5, 8'h5A, 8'h0D, 8'h0A});
    drain();
    // maximum of one byte: the start signature alone overflows
    set_framing(4'd3, 64'h00FF_5AA5, 4'd2, 64'h0A0D, 13'd1);
    send_seq('{8'hA5, 8'h5A, 8'hFF});
    drain();
    // maximum of six: end on the sixth byte wins, then a plain overflow
    set_framing(4'd3, 64'h00FF_5AA5, 4'd2, 64'h0A0D, 13'd6);
    send_seq('{8'hA5, 8'h5A, 8'hFF, 8'h42, 8'h0D, 8'h0A});
    send_seq('{8'hA5, 8'h5A, 8'hFF, 8'h01, 8'h02, 8'h03});
    drain();

    // random settings, longest and shortest signatures first
    random_phase(10, 4'd8, 4'd8, 13'd40);
    random_phase(10, 4'd1, 4'd1, 13'd4096);
    repeat (7) random_phase(6, pick_len(), pick_len(), pick_max());

    $display("summary: %0d bytes in, %0d results checked, %0d register writes",
             n_sent, tracker.n_checked, n_cfg);
    $display("summary: %0d packets closed on the end signature, %0d abandoned on overflow",
             tracker.n_ended, tracker.n_overflows);
    if (tracker.n_errors == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
